>>> design/sfd_pkg.sv
package sfd_pkg;

	// Framing bytes of the link.
	localparam logic [7:0] FLAG_BYTE = 8'h7e;
	localparam logic [7:0] ESC_BYTE  = 8'h7d;
	localparam logic [7:0] ESC_XOR   = 8'h20;

	// Reflected CRC-32 generator polynomial.
	localparam logic [31:0] CRC_POLY = 32'hedb88320;

	// Body layout: version, kind, session, request, payload, CRC.
	localparam int MIN_BODY      = 18;
	localparam int MAX_KIND      = 7;
	localparam int HDR_VERSION   = 0;
	localparam int HDR_KIND      = 1;
	localparam int SESSION_START = 2;
	localparam int SESSION_BYTES = 8;
	localparam int REQUEST_START = 10;
	localparam int REQUEST_BYTES = 4;
	localparam int PAYLOAD_START = 14;
	localparam int CRC_BYTES     = 4;
	localparam logic [7:0] VERSION_ONE = 8'h01;

	// Width of the payload length field.
	localparam int PLEN_W = 7;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_CONSUMED = 2'd0,
		ST_NOISE    = 2'd1,
		ST_BAD      = 2'd2,
		ST_GOOD     = 2'd3
	} status_t;

	// One word of work handed from the front end to the back end.
	typedef struct packed {
		status_t            status;
		logic [2:0]         kind;
		logic [63:0]        session;
		logic [31:0]        request;
		logic [PLEN_W-1:0]  plen;
	} cmd_t;

	// Advance a reflected CRC-32 by one byte, least significant bit first.
	function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] d);
		logic [31:0] x;
		x = c ^ {24'h000000, d};
		for (int k = 0; k < 8; k++) begin
			x = (x >> 1) ^ (CRC_POLY & {32{x[0]}});
		end
		return x;
	endfunction

endpackage

>>> design/sfd_rx_if.sv
interface sfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] wire_byte;

	modport source (output valid, output wire_byte, input ready);
	modport sink (input valid, input wire_byte, output ready);
endinterface

>>> design/sfd_tx_if.sv
interface sfd_tx_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  kind;
	logic [63:0] session;
	logic [31:0] request;
	logic [6:0]  payload_len;
	logic [7:0]  payload_byte;
	logic        payload_valid;
	logic        last;

	modport source (output valid, output status, output kind, output session,
		output request, output payload_len, output payload_byte,
		output payload_valid, output last, input ready);
	modport sink (input valid, input status, input kind, input session,
		input request, input payload_len, input payload_byte,
		input payload_valid, input last, output ready);
endinterface

>>> design/sfd_ram.sv
module sfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

>>> design/sfd_cmd_fifo.sv
module sfd_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  sfd_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output sfd_pkg::cmd_t pop_cmd,
	output logic          empty
);
	sfd_pkg::cmd_t entry_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    fill_q;

	assign full    = fill_q == 2'd2;
	assign empty   = fill_q == 2'd0;
	assign pop_cmd = entry_q[rptr_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_cmd;
		end
	end
endmodule

>>> design/sfd_front.sv
module sfd_front #(
	parameter int MAX_BODY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	sfd_rx_if.sink                      rx,
	output logic                        push,
	output sfd_pkg::cmd_t               push_cmd,
	input  logic                        full,
	input  logic                        done,
	output logic                        ram_we,
	output logic [$clog2(MAX_BODY)-1:0] ram_waddr,
	output logic [7:0]                  ram_wdata
);
	localparam int CW = $clog2(MAX_BODY + 1);
	localparam int AW = $clog2(MAX_BODY);

	// Control state.
	logic          in_frame_q;
	logic          esc_q;
	logic          ovf_q;
	logic [CW-1:0] count_q;
	logic          pending_q;

	// Running check state of the current body.
	logic [31:0] crc_q;
	logic [31:0] last4_q;
	logic        ver_ok_q;
	logic [7:0]  kind_byte_q;
	logic [63:0] session_q;
	logic [31:0] request_q;

	logic       acc;
	logic [7:0] b;
	logic [7:0] d;
	logic       is_flag;
	logic       checked;
	logic       hdr_ok;
	logic       good;
	logic       noise;
	logic       start_esc;
	logic       store;
	logic       full_body;
	logic [CW-1:0] plen_c;
	logic [CW-1:0] sess_off;
	logic [CW-1:0] req_off;

	assign b         = rx.wire_byte;
	assign rx.ready  = !full && !pending_q;
	assign acc       = rx.valid && rx.ready;
	assign d         = esc_q ? (b ^ sfd_pkg::ESC_XOR) : b;
	assign full_body = count_q == CW'(MAX_BODY);
	assign plen_c    = count_q - CW'(sfd_pkg::MIN_BODY);
	assign sess_off  = count_q - CW'(sfd_pkg::SESSION_START);
	assign req_off   = count_q - CW'(sfd_pkg::REQUEST_START);

	// Classify the incoming word against the framing state.
	always_comb begin
		is_flag   = b == sfd_pkg::FLAG_BYTE;
		checked   = in_frame_q && (count_q != '0 || ovf_q || esc_q);
		hdr_ok    = ver_ok_q && kind_byte_q >= 8'd1
			&& kind_byte_q <= 8'(sfd_pkg::MAX_KIND) && session_q != 64'd0;
		good      = checked && !ovf_q && !esc_q && count_q >= CW'(sfd_pkg::MIN_BODY)
			&& hdr_ok && (~crc_q == last4_q);
		noise     = !is_flag && (!in_frame_q
			|| (count_q == '0 && !esc_q && !ovf_q && b != sfd_pkg::VERSION_ONE));
		start_esc = !is_flag && !noise && !ovf_q && !esc_q && b == sfd_pkg::ESC_BYTE;
		store     = !is_flag && !noise && !ovf_q && !start_esc;
	end

	// Build the word for the back end.
	always_comb begin
		push_cmd = '0;
		if (is_flag) begin
			if (good) begin
				push_cmd.status  = sfd_pkg::ST_GOOD;
				push_cmd.kind    = kind_byte_q[2:0];
				push_cmd.session = session_q;
				push_cmd.request = request_q;
				push_cmd.plen    = sfd_pkg::PLEN_W'(plen_c);
			end else if (checked) begin
				push_cmd.status = sfd_pkg::ST_BAD;
			end else begin
				push_cmd.status = sfd_pkg::ST_CONSUMED;
			end
		end else if (noise) begin
			push_cmd.status = sfd_pkg::ST_NOISE;
		end else begin
			push_cmd.status = sfd_pkg::ST_CONSUMED;
		end
	end

	assign push      = acc;
	assign ram_we    = acc && store && !full_body;
	assign ram_waddr = count_q[AW-1:0];
	assign ram_wdata = d;

	// Framing state machine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			esc_q      <= 1'b0;
			ovf_q      <= 1'b0;
			count_q    <= '0;
		end else if (acc) begin
			if (is_flag) begin
				in_frame_q <= 1'b1;
				esc_q      <= 1'b0;
				ovf_q      <= 1'b0;
				count_q    <= '0;
			end else if (noise) begin
				in_frame_q <= 1'b0;
			end else if (start_esc) begin
				esc_q <= 1'b1;
			end else if (store) begin
				esc_q <= 1'b0;
				if (full_body) begin
					ovf_q   <= 1'b1;
					count_q <= '0;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
		end
	end

	// Hold input while the back end still reads a good frame from the buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
		end else if (acc && is_flag && good) begin
			pending_q <= 1'b1;
		end else if (done) begin
			pending_q <= 1'b0;
		end
	end

	// CRC runs four bytes behind the newest byte, so at the flag it covers
	// everything but the trailing check field, which sits in last4_q.
	always_ff @(posedge clk) begin
		if (acc && is_flag) begin
			crc_q <= '1;
		end else if (ram_we) begin
			last4_q <= {d, last4_q[31:8]};
			if (count_q >= CW'(sfd_pkg::CRC_BYTES)) begin
				crc_q <= sfd_pkg::crc32_byte(crc_q, last4_q[7:0]);
			end
			if (count_q == CW'(sfd_pkg::HDR_VERSION)) begin
				ver_ok_q <= d == sfd_pkg::VERSION_ONE;
			end
			if (count_q == CW'(sfd_pkg::HDR_KIND)) begin
				kind_byte_q <= d;
			end
			if (count_q >= CW'(sfd_pkg::SESSION_START)
				&& count_q < CW'(sfd_pkg::SESSION_START + sfd_pkg::SESSION_BYTES)) begin
				session_q[8 * sess_off[2:0] +: 8] <= d;
			end
			if (count_q >= CW'(sfd_pkg::REQUEST_START)
				&& count_q < CW'(sfd_pkg::REQUEST_START + sfd_pkg::REQUEST_BYTES)) begin
				request_q[8 * req_off[1:0] +: 8] <= d;
			end
		end
	end
endmodule

>>> design/sfd_back.sv
module sfd_back #(
	parameter int MAX_BODY = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        empty,
	input  sfd_pkg::cmd_t               pop_cmd,
	output logic                        pop,
	output logic                        done,
	output logic                        ram_re,
	output logic [$clog2(MAX_BODY)-1:0] ram_raddr,
	input  logic [7:0]                  ram_rdata,
	sfd_tx_if.source                    tx
);
	localparam int AW = $clog2(MAX_BODY);
	localparam int PW = sfd_pkg::PLEN_W;

	typedef enum logic {
		S_IDLE,
		S_BURST
	} state_t;

	state_t        state_q;
	sfd_pkg::cmd_t cmd_q;
	logic [PW-1:0] idx_q;

	logic          out_valid_q;
	logic [1:0]    out_status_q;
	logic [2:0]    out_kind_q;
	logic [63:0]   out_session_q;
	logic [31:0]   out_request_q;
	logic [PW-1:0] out_plen_q;
	logic [7:0]    out_byte_q;
	logic          out_pvalid_q;
	logic          out_last_q;

	logic          can_load;
	logic          start_burst;
	logic          last_byte;
	logic [PW-1:0] rd_idx;
	logic [PW:0]   rd_addr_full;

	assign can_load    = !out_valid_q || tx.ready;
	assign pop         = state_q == S_IDLE && !empty && can_load;
	assign start_burst = pop_cmd.status == sfd_pkg::ST_GOOD && pop_cmd.plen != '0;
	assign last_byte   = idx_q == cmd_q.plen - PW'(1);

	// Read address of the next payload byte.
	always_comb begin
		ram_re = 1'b0;
		rd_idx = '0;
		done   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (pop) begin
					ram_re = start_burst;
					done   = pop_cmd.status == sfd_pkg::ST_GOOD && !start_burst;
				end
			end
			S_BURST: begin
				if (can_load) begin
					ram_re = !last_byte;
					rd_idx = idx_q + PW'(1);
					done   = last_byte;
				end
			end
			default: begin
				ram_re = 1'b0;
			end
		endcase
		rd_addr_full = (PW + 1)'(sfd_pkg::PAYLOAD_START) + {1'b0, rd_idx};
	end

	assign ram_raddr = rd_addr_full[AW-1:0];

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cmd_q         <= '0;
			idx_q         <= '0;
			out_valid_q   <= 1'b0;
			out_status_q  <= '0;
			out_kind_q    <= '0;
			out_session_q <= '0;
			out_request_q <= '0;
			out_plen_q    <= '0;
			out_byte_q    <= '0;
			out_pvalid_q  <= 1'b0;
			out_last_q    <= 1'b0;
		end else begin
			if (out_valid_q && tx.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (start_burst) begin
							cmd_q   <= pop_cmd;
							idx_q   <= '0;
							state_q <= S_BURST;
						end else begin
							out_valid_q   <= 1'b1;
							out_status_q  <= pop_cmd.status;
							out_kind_q    <= pop_cmd.kind;
							out_session_q <= pop_cmd.session;
							out_request_q <= pop_cmd.request;
							out_plen_q    <= pop_cmd.plen;
							out_byte_q    <= '0;
							out_pvalid_q  <= 1'b0;
							out_last_q    <= 1'b1;
						end
					end
				end
				S_BURST: begin
					if (can_load) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= cmd_q.status;
						out_kind_q    <= cmd_q.kind;
						out_session_q <= cmd_q.session;
						out_request_q <= cmd_q.request;
						out_plen_q    <= cmd_q.plen;
						out_byte_q    <= ram_rdata;
						out_pvalid_q  <= 1'b1;
						out_last_q    <= last_byte;
						idx_q         <= idx_q + PW'(1);
						if (last_byte) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign tx.valid         = out_valid_q;
	assign tx.status        = out_status_q;
	assign tx.kind          = out_kind_q;
	assign tx.session       = out_session_q;
	assign tx.request       = out_request_q;
	assign tx.payload_len   = out_plen_q;
	assign tx.payload_byte  = out_byte_q;
	assign tx.payload_valid = out_pvalid_q;
	assign tx.last          = out_last_q;
endmodule

>>> design/stuffed_frame_deframer_crc32_core.sv
// Byte-stuffed frame deframer with CRC-32 check. Each word on rx is one wire
// byte and gives one result word on tx, except the closing flag of a good
// frame, which gives one word per payload byte (or a single word for an empty
// payload), the final word marked by last. The front end takes one byte per
// cycle, stores the unescaped body in a MAX_BODY-byte buffer and keeps a
// running CRC and the header fields as the bytes arrive, so the check at the
// flag costs nothing extra. A two-word queue separates it from the back end,
// which drives a registered output. After the closing flag of a good frame,
// rx stays stalled until the back end has read the last payload byte from the
// body buffer, and longer under back pressure on tx. Otherwise the rate is
// one byte per cycle while the queue has room.
module stuffed_frame_deframer_crc32_core #(
	parameter int MAX_BODY = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	sfd_rx_if.sink   rx,
	sfd_tx_if.source tx
);
	localparam int AW = $clog2(MAX_BODY);

	sfd_pkg::cmd_t push_cmd;
	sfd_pkg::cmd_t pop_cmd;
	logic          push;
	logic          pop;
	logic          full;
	logic          empty;
	logic          done;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	// Front end: framing, unstuffing and frame checks.
	sfd_front #(.MAX_BODY(MAX_BODY)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (full),
		.done      (done),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata)
	);

	// Body buffer.
	sfd_ram #(.WIDTH(8), .DEPTH(MAX_BODY)) u_body_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Queue of words between the two halves.
	sfd_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	// Back end: result delivery and payload read-out.
	sfd_back #(.MAX_BODY(MAX_BODY)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.pop_cmd   (pop_cmd),
		.pop       (pop),
		.done      (done),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.tx        (tx)
	);
endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

import sfd_pkg::*;

localparam int BODY_DEPTH  = 64;
localparam int MAX_PAYLOAD = BODY_DEPTH - MIN_BODY;

// One result word as the block presents it on tx.
typedef struct packed {
	status_t     status;
	logic [2:0]  kind;
	logic [63:0] session;
	logic [31:0] request;
	logic [6:0]  plen;
	logic [7:0]  pbyte;
	logic        pvalid;
	logic        last;
} deframe_word_t;

// Reflected CRC-32, one byte, shifted out bit by bit.
function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] data);
	logic [31:0] acc;
	acc = crc;
	for (int bit_idx = 0; bit_idx < 8; bit_idx++) begin
		if (acc[0] ^ data[bit_idx])
			acc = (acc >> 1) ^ CRC_POLY;
		else
			acc = acc >> 1;
	end
	return acc;
endfunction

// Mirrors the deframer state and holds the result words still to come.
class deframe_scoreboard;
	bit            in_frame;
	bit            esc_pending;
	bit            overflowed;
	int unsigned   body_len;
	logic [7:0]    body [BODY_DEPTH];
	deframe_word_t expected_q [$];
	int unsigned   fail_count;
	int unsigned   words_checked;
	int unsigned   good_frames;
	int unsigned   bad_frames;
	int unsigned   overflows;
	int unsigned   noise_words;

	function logic [63:0] le_field(input int unsigned start, input int unsigned nbytes);
		logic [63:0] value;
		value = '0;
		for (int i = 0; i < nbytes; i++)
			value |= 64'(body[start + i]) << (8 * i);
		return value;
	endfunction

	function void push_plain(input status_t st);
		deframe_word_t w;
		w = '0;
		w.status = st;
		w.last   = 1'b1;
		expected_q.push_back(w);
	endfunction

	// Work out the result words that one accepted wire word causes.
	function void note_byte(input logic [7:0] wire_in);
		bit            closing;
		bit            ok;
		logic [7:0]    b;
		logic [63:0]   session;
		logic [31:0]   request;
		logic [31:0]   crc;
		int unsigned   plen;
		deframe_word_t w;
		b = wire_in;
		if (b == FLAG_BYTE) begin
			closing = in_frame && (body_len != 0 || overflowed || esc_pending);
			ok = 1'b0;
			if (closing && !overflowed && !esc_pending && body_len >= MIN_BODY) begin
				session = le_field(SESSION_START, SESSION_BYTES);
				request = 32'(le_field(REQUEST_START, REQUEST_BYTES));
				crc = '1;
				for (int i = 0; i < body_len - CRC_BYTES; i++)
					crc = crc_step(crc, body[i]);
				crc = ~crc;
				ok = body[HDR_VERSION] == VERSION_ONE && body[HDR_KIND] >= 1 &&
					body[HDR_KIND] <= MAX_KIND && session != 0 &&
					crc == 32'(le_field(body_len - CRC_BYTES, CRC_BYTES));
			end
			if (ok) begin
				plen = body_len - MIN_BODY;
				good_frames++;
				w = '0;
				w.status  = ST_GOOD;
				w.kind    = body[HDR_KIND][2:0];
				w.session = session;
				w.request = request;
				w.plen    = 7'(plen);
				if (plen == 0) begin
					w.last = 1'b1;
					expected_q.push_back(w);
				end else begin
					for (int i = 0; i < plen; i++) begin
						w.pbyte  = body[PAYLOAD_START + i];
						w.pvalid = 1'b1;
						w.last   = (i == plen - 1);
						expected_q.push_back(w);
					end
				end
			end else begin
				if (closing)
					bad_frames++;
				push_plain(closing ? ST_BAD : ST_CONSUMED);
			end
			in_frame    = 1'b1;
			body_len    = 0;
			esc_pending = 1'b0;
			overflowed  = 1'b0;
			return;
		end

		// Outside a frame, or a first body byte that is not the version.
		if (!in_frame || (body_len == 0 && !esc_pending && !overflowed && b != VERSION_ONE)) begin
			in_frame = 1'b0;
			noise_words++;
			push_plain(ST_NOISE);
			return;
		end

		push_plain(ST_CONSUMED);
		if (overflowed)
			return;
		if (!esc_pending && b == ESC_BYTE) begin
			esc_pending = 1'b1;
			return;
		end
		if (esc_pending) begin
			b = b ^ ESC_XOR;
			esc_pending = 1'b0;
		end
		if (body_len >= BODY_DEPTH) begin
			overflowed = 1'b1;
			overflows++;
			body_len = 0;
		end else begin
			body[body_len] = b;
			body_len++;
		end
	endfunction

	function void compare_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare one result word with the oldest one still expected.
	function void check_word(input deframe_word_t got);
		deframe_word_t want;
		words_checked++;
		if (expected_q.size() == 0) begin
			$error("result word with none expected, status %0d", got.status);
			fail_count++;
			return;
		end
		want = expected_q.pop_front();
		compare_field("status", want.status, got.status);
		compare_field("kind", want.kind, got.kind);
		compare_field("session", want.session, got.session);
		compare_field("request", want.request, got.request);
		compare_field("payload_len", want.plen, got.plen);
		compare_field("payload_byte", want.pbyte, got.pbyte);
		compare_field("payload_valid", want.pvalid, got.pvalid);
		compare_field("last", want.last, got.last);
	endfunction
endclass

module tb;

	localparam int RANDOM_BYTES   = 220;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int SRC_IDLE [4]   = '{0, 84, 0, 35};
	localparam int SINK_STALL [4] = '{0, 0, 84, 35};

	typedef enum int {
		FL_NONE,
		FL_CRC,
		FL_VERSION,
		FL_KIND,
		FL_SESSION,
		FL_SHORT,
		FL_DANGLE,
		FL_NOISE
	} frame_flaw_t;

	logic clk;
	logic arst_n;

	sfd_rx_if rx_bus ();
	sfd_tx_if tx_bus ();

	deframe_scoreboard sb = new();

	int unsigned bytes_sent;
	int unsigned quiet_cycles;
	int          src_idle_pct;
	int          sink_stall_pct;
	bit          hold_request;
	int          hold_left;

	stuffed_frame_deframer_crc32_core #(
		.MAX_BODY(BODY_DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_bus),
		.tx    (tx_bus)
	);

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: random stalls, plus one long hold-off when asked for.
	initial begin
		tx_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_request) begin
				hold_left = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left != 0) begin
				tx_bus.ready <= 1'b0;
				hold_left--;
			end else begin
				tx_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Monitor both channels at each edge; input words are noted first.
	always @(posedge clk) begin
		deframe_word_t got;
		if (arst_n) begin
			quiet_cycles++;
			if (rx_bus.valid && rx_bus.ready) begin
				sb.note_byte(rx_bus.wire_byte);
				quiet_cycles = 0;
			end
			if (tx_bus.valid && tx_bus.ready) begin
				got.status  = status_t'(tx_bus.status);
				got.kind    = tx_bus.kind;
				got.session = tx_bus.session;
				got.request = tx_bus.request;
				got.plen    = tx_bus.payload_len;
				got.pbyte   = tx_bus.payload_byte;
				got.pvalid  = tx_bus.payload_valid;
				got.last    = tx_bus.last;
				sb.check_word(got);
				quiet_cycles = 0;
			end
		end
	end

	// Watchdog: too long without any word moving on either side.
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// Offer one wire word, with random idle cycles in front of it.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx_bus.valid <= 1'b0;
			@(posedge clk);
		end
		rx_bus.valid     <= 1'b1;
		rx_bus.wire_byte <= b;
		do @(posedge clk); while (!rx_bus.ready);
		bytes_sent++;
	endtask

	// Build a frame body, apply one flaw, then stuff it onto the link.
	task automatic send_frame(input logic [2:0] kind, input logic [63:0] session,
		input logic [31:0] request, input int payload_n, input frame_flaw_t flaw,
		input bit open_flag);
		logic [7:0]  body [$];
		logic [7:0]  pb;
		logic [31:0] crc;
		int          pick;
		if (flaw == FL_SESSION)
			session = '0;
		else if (session == 0)
			session = 64'd1;
		body.push_back(VERSION_ONE);
		if (flaw == FL_KIND)
			body.push_back(($urandom_range(1) != 0) ? 8'd0 : 8'($urandom_range(255, MAX_KIND + 1)));
		else
			body.push_back({5'd0, kind});
		for (int i = 0; i < SESSION_BYTES; i++)
			body.push_back(session[8 * i +: 8]);
		for (int i = 0; i < REQUEST_BYTES; i++)
			body.push_back(request[8 * i +: 8]);
		// Bias the payload towards the bytes that need stuffing.
		for (int i = 0; i < payload_n; i++) begin
			pick = $urandom_range(31);
			pb = (pick < 4) ? FLAG_BYTE : (pick < 8) ? ESC_BYTE : 8'($urandom_range(255));
			body.push_back(pb);
		end
		if (flaw == FL_VERSION) begin
			do body[HDR_VERSION] = 8'($urandom_range(255));
			while (body[HDR_VERSION] == VERSION_ONE || body[HDR_VERSION] == FLAG_BYTE);
		end
		crc = '1;
		foreach (body[i])
			crc = crc_step(crc, body[i]);
		crc = ~crc;
		for (int i = 0; i < CRC_BYTES; i++)
			body.push_back(crc[8 * i +: 8]);
		if (flaw == FL_CRC)
			body[body.size() - 1 - $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
		if (flaw == FL_SHORT) begin
			pick = $urandom_range(MIN_BODY - 1, 1);
			while (body.size() > pick)
				void'(body.pop_back());
		end

		if (flaw == FL_NOISE)
			repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
		if (open_flag || flaw == FL_NOISE)
			send_byte(FLAG_BYTE);
		foreach (body[i]) begin
			if (i > 0 && (body[i] == FLAG_BYTE || body[i] == ESC_BYTE ||
				$urandom_range(15) == 0)) begin
				send_byte(ESC_BYTE);
				send_byte(body[i] ^ ESC_XOR);
			end else begin
				send_byte(body[i]);
			end
		end
		if (flaw == FL_DANGLE)
			send_byte(ESC_BYTE);
		send_byte(FLAG_BYTE);
	endtask

	// Mostly well-formed frames with small payloads; some long, overflowing or broken.
	task automatic send_random_frame();
		frame_flaw_t flaw;
		int          pick;
		int          n;
		if ($urandom_range(99) < 65)
			flaw = FL_NONE;
		else
			flaw = frame_flaw_t'($urandom_range(FL_NOISE, FL_CRC));
		pick = $urandom_range(19);
		if (pick == 0)
			n = $urandom_range(MAX_PAYLOAD + 4, MAX_PAYLOAD + 1);
		else if (pick < 3)
			n = $urandom_range(MAX_PAYLOAD);
		else
			n = $urandom_range(6);
		send_frame(3'($urandom_range(MAX_KIND, 1)), {$urandom(), $urandom()}, $urandom(),
			n, flaw, $urandom_range(2) == 0);
	endtask

	// Stimulus and end of run.
	initial begin
		int unsigned target;
		rx_bus.valid     <= 1'b0;
		rx_bus.wire_byte <= 8'h00;
		arst_n           <= 1'b0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Noise outside a frame, at both extremes of the byte.
		send_byte(8'h00);
		send_byte(8'hff);
		// Opening flag, then a flag with nothing pending.
		send_byte(FLAG_BYTE);
		send_byte(FLAG_BYTE);
		// An escape as the first body byte drops the frame; the next byte is noise.
		send_byte(ESC_BYTE);
		send_byte(VERSION_ONE);
		// Too short a body, then a dangling escape: both bad frames.
		send_byte(FLAG_BYTE);
		send_byte(VERSION_ONE);
		send_byte(FLAG_BYTE);
		send_byte(VERSION_ONE);
		send_byte(ESC_BYTE);
		send_byte(FLAG_BYTE);
		// Good frame with an empty payload and all-ones fields.
		send_frame(3'(MAX_KIND), '1, '1, 0, FL_NONE, 1'b0);

		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct   = SRC_IDLE[ph];
			sink_stall_pct = SINK_STALL[ph];
			target = bytes_sent + RANDOM_BYTES / 4;
			if (ph == 0) begin
				// Long receiver hold-off under a full-size frame, then an overflow.
				hold_request = 1'b1;
				send_frame(3'd1, {$urandom(), $urandom()}, '0, MAX_PAYLOAD, FL_NONE, 1'b1);
				send_frame(3'($urandom_range(MAX_KIND, 1)), {$urandom(), $urandom()},
					$urandom(), MAX_PAYLOAD + 1, FL_NONE, 1'b0);
			end
			while (bytes_sent < target)
				send_random_frame();
		end
		rx_bus.valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d wire words and %0d result words over four idling phases.",
			bytes_sent, sb.words_checked);
		$display("Frames: %0d good, %0d bad, %0d overflowed; %0d noise words.",
			sb.good_frames, sb.bad_frames, sb.overflows, sb.noise_words);
		if (sb.fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> files.f
design/sfd_pkg.sv
design/sfd_rx_if.sv
design/sfd_tx_if.sv
design/sfd_ram.sv
design/sfd_cmd_fifo.sv
design/sfd_front.sv
design/sfd_back.sv
design/stuffed_frame_deframer_crc32_core.sv
test/tb.sv
